// ----- sv/ftts_pkg.sv -----
// Shared types and constants for the fixed-timestep tick scheduler.
// Holds the frame and result item structs, register map and reset values.
// No dependencies; the top level and its checker refer to it by scoped names.
package ftts_pkg;

	// One frame item as it arrives on the input channel.
	typedef struct packed {
		logic               scene_mode;
		logic               scene_physics_on;
		logic [1:0]         advance_mode;
		logic               step_held;
		logic               physics_allowed;
		logic               fixed_mode;
		logic [31:0]        frame_seconds;
		logic signed [23:0] scale_factor;
	} frame_t;

	// One result item as it leaves on the output channel.
	typedef struct packed {
		logic               update_logic;
		logic [31:0]        camera_dt;
		logic signed [39:0] simulation_dt;
		logic [5:0]         committed_ticks;
		logic [16:0]        alpha;
	} result_t;

	// Advance mode codes; the fourth code behaves as paused.
	localparam logic [1:0] ADV_PAUSED = 2'd0;
	localparam logic [1:0] ADV_RUN    = 2'd1;
	localparam logic [1:0] ADV_HELD   = 2'd2;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_FIXED_DT  = 2'd0;
	localparam logic [1:0] REG_MAX_STEPS = 2'd1;
	localparam logic [1:0] REG_MAX_TICKS = 2'd2;

	// Register reset values.
	localparam logic [31:0] FIXED_DT_RST  = 32'd279620;
	localparam logic [5:0]  MAX_STEPS_RST = 6'd8;
	localparam logic [5:0]  MAX_TICKS_RST = 6'd32;

	// Saturation bounds of the signed 40-bit seconds format.
	localparam logic [39:0] S40_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [39:0] S40_MIN = 40'h80_0000_0000;

	// Alpha value that stands for one.
	localparam logic [16:0] ALPHA_ONE = 17'h1_0000;

	// Last bit index of the serial multiplier and of the alpha divider.
	localparam logic [4:0] MUL_LAST = 5'd23;
	localparam logic [4:0] DIV_LAST = 5'd15;

endpackage

// ----- sv/fixed_timestep_tick_scheduler_unit.sv -----
// Top level of the fixed-timestep tick scheduler: APB registers, sequencer,
// bit-serial multiplier, step loop and restoring alpha divider.
// Depends on ftts_pkg for the item structs, register map and constants.

// The block takes one frame item and returns one result item. It works on one
// item at a time: frame_stall is high from the cycle after an item is taken
// until its result has moved into the output register, and a new frame may be
// taken while that result still waits for the consumer. A frame in scene mode
// with scene physics off goes straight to the result. Every other frame runs a
// 24-bit bit-serial multiplier, one multiplier bit per cycle; stepping fixed-step
// frames first pass the tick update. Stepping variable-mode frames then add the
// accumulator update, the step loop with one fixed_dt subtraction per committed
// step and, when a positive remainder is left, the one-bit-per-cycle alpha
// divider that gives 16 quotient bits.
// Registers lie at byte addresses 0 (fixed_dt), 4 (max_steps_per_frame) and
// 8 (max_fixed_ticks) and may be written only while the block is idle.
module fixed_timestep_tick_scheduler_unit (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Frame channel
	input  logic               frame_valid,
	output logic               frame_stall,
	input  ftts_pkg::frame_t   frame,
	// Result channel
	output logic               result_valid,
	input  logic               result_stall,
	output ftts_pkg::result_t  result
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b000_0001,
		ST_TICK = 7'b000_0010,
		ST_MUL  = 7'b000_0100,
		ST_ACC  = 7'b000_1000,
		ST_STEP = 7'b001_0000,
		ST_DIV  = 7'b010_0000,
		ST_FIN  = 7'b100_0000
	} state_t;

	state_t             state_q;
	logic               result_valid_q;
	ftts_pkg::result_t  result_q;

	// Configuration registers
	logic [31:0]        fixed_dt_q;
	logic [5:0]         max_steps_q;
	logic [5:0]         max_ticks_q;

	// Accumulators kept across frames
	logic [39:0]        ta_q;
	logic [31:0]        tick_q;

	// Per-item registers
	logic               fixed_q;
	logic               step_q;
	logic               upd_q;
	logic [31:0]        secs_q;
	logic [23:0]        ts_pos_q;
	logic [39:0]        res_sim_q;
	logic [5:0]         ticks_q;
	logic [16:0]        alpha_q;

	// Serial multiplier and divider registers
	logic [31:0]        mcand_q;
	logic [23:0]        mplier_q;
	logic [33:0]        hi_q;
	logic [23:0]        lo_q;
	logic [4:0]         cnt_q;
	logic [31:0]        rem_q;

	logic               cfg_wr;
	logic               frame_accept;
	logic               frame_off;
	logic               can_step;
	logic [23:0]        ts_pos;
	logic               res_load;

	logic               mul_last;
	logic [33:0]        mul_add;
	logic [33:0]        mul_sum;
	logic [33:0]        mul_hi_nxt;
	logic [23:0]        mul_lo_nxt;
	logic [39:0]        prod_sh16;
	logic [39:0]        prod_low;

	logic [32:0]        tk_sum;
	logic [31:0]        tk_sat;
	logic [15:0]        tk_whole;
	logic [5:0]         tk_ticks;
	logic [31:0]        tk_rem;

	logic [40:0]        acc_sum;
	logic [39:0]        acc_sat;

	logic               step_go;
	logic               step_cap;
	logic [39:0]        ta_diff;
	logic [39:0]        ta_fin;
	logic               alpha_div;

	logic [32:0]        div_r2;
	logic [32:0]        div_diff;
	logic               div_ge;

	assign pready       = 1'b1;
	assign cfg_wr       = psel & penable & pwrite;
	assign frame_stall  = (state_q != ST_IDLE);
	assign frame_accept = frame_valid & ~frame_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_dt_q  <= ftts_pkg::FIXED_DT_RST;
			max_steps_q <= ftts_pkg::MAX_STEPS_RST;
			max_ticks_q <= ftts_pkg::MAX_TICKS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ftts_pkg::REG_FIXED_DT:  fixed_dt_q  <= pwdata;
				ftts_pkg::REG_MAX_STEPS: max_steps_q <= pwdata[5:0];
				ftts_pkg::REG_MAX_TICKS: max_ticks_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// Configuration register reads.
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			ftts_pkg::REG_FIXED_DT:  prdata = fixed_dt_q;
			ftts_pkg::REG_MAX_STEPS: prdata = {26'd0, max_steps_q};
			ftts_pkg::REG_MAX_TICKS: prdata = {26'd0, max_ticks_q};
			default:                 prdata = '0;
		endcase
	end

	// Frame decode: physics off, step permission and the clamped time scale.
	assign frame_off = frame.scene_mode & ~frame.scene_physics_on;
	assign can_step  = ((frame.advance_mode == ftts_pkg::ADV_RUN) ||
		((frame.advance_mode == ftts_pkg::ADV_HELD) && frame.step_held)) &&
		frame.physics_allowed;
	assign ts_pos    = frame.scale_factor[23] ? 24'd0 : frame.scale_factor;

	// Multiplier step: add the multiplicand for a set bit, subtract it on the
	// sign bit, then shift the product one place to the right.
	assign mul_last   = (cnt_q == ftts_pkg::MUL_LAST);
	assign mul_add    = mplier_q[0] ? {2'b00, mcand_q} : 34'd0;
	assign mul_sum    = mul_last ? (hi_q - mul_add) : (hi_q + mul_add);
	assign mul_hi_nxt = {mul_sum[33], mul_sum[33:1]};
	assign mul_lo_nxt = {mul_sum[0], lo_q[23:1]};
	assign prod_sh16  = {mul_hi_nxt[31:0], mul_lo_nxt[23:16]};
	assign prod_low   = {mul_hi_nxt[15:0], mul_lo_nxt};

	// Fixed-step tick accumulation with saturation and the per-frame cap.
	assign tk_sum   = {1'b0, tick_q} + {9'd0, ts_pos_q};
	assign tk_sat   = tk_sum[32] ? 32'hFFFF_FFFF : tk_sum[31:0];
	assign tk_whole = tk_sat[31:16];
	assign tk_ticks = (tk_whole < {10'd0, max_ticks_q}) ? tk_whole[5:0] : max_ticks_q;
	assign tk_rem   = tk_sat - {10'd0, tk_ticks, 16'd0};

	// Variable-mode time accumulation, saturated to the signed 40-bit range.
	assign acc_sum = {ta_q[39], ta_q} + {res_sim_q[39], res_sim_q};
	always_comb begin
		if (acc_sum[40] != acc_sum[39]) begin
			acc_sat = acc_sum[40] ? ftts_pkg::S40_MIN : ftts_pkg::S40_MAX;
		end else begin
			acc_sat = acc_sum[39:0];
		end
	end

	// Step loop: one fixed_dt subtraction per cycle until below or capped.
	assign step_go  = ($signed({ta_q[39], ta_q}) >= $signed({9'd0, fixed_dt_q})) &&
		(ticks_q < max_steps_q);
	assign step_cap = (ticks_q == max_steps_q);
	assign ta_diff  = ta_q - {8'd0, fixed_dt_q};
	assign ta_fin   = step_cap ? 40'd0 : ta_q;
	// Once the loop stops short of the cap the remainder is below fixed_dt,
	// so a positive remainder always needs the divider.
	assign alpha_div = (fixed_dt_q != 32'd0) && !step_cap && !ta_q[39] && (ta_q != 40'd0);

	// Restoring divider step: one quotient bit of remainder * 65536 / fixed_dt.
	assign div_r2   = {rem_q, 1'b0};
	assign div_diff = div_r2 - {1'b0, fixed_dt_q};
	assign div_ge   = (div_r2 >= {1'b0, fixed_dt_q});

	assign res_load = (state_q == ST_FIN) && (!result_valid_q || !result_stall);

	// Sequencer, result valid and the accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			ta_q           <= '0;
			tick_q         <= '0;
		end else begin
			result_valid_q <= res_load | (result_valid_q & result_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (frame_accept) begin
						if (frame_off || !can_step) begin
							ta_q   <= '0;
							tick_q <= '0;
						end
						if (frame_off) begin
							state_q <= ST_FIN;
						end else if (frame.fixed_mode && can_step) begin
							state_q <= ST_TICK;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_TICK: begin
					tick_q  <= tk_rem;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_last) begin
						state_q <= (!fixed_q && step_q) ? ST_ACC : ST_FIN;
					end
				end
				ST_ACC: begin
					ta_q    <= acc_sat;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (step_go) begin
						ta_q <= ta_diff;
					end else begin
						ta_q    <= ta_fin;
						state_q <= alpha_div ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (cnt_q == ftts_pkg::DIV_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Per-item datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (frame_accept) begin
					fixed_q   <= frame.fixed_mode;
					step_q    <= can_step;
					upd_q     <= ~frame_off;
					secs_q    <= frame.frame_seconds;
					ts_pos_q  <= ts_pos;
					res_sim_q <= '0;
					ticks_q   <= '0;
					alpha_q   <= (frame.fixed_mode && can_step && !frame_off) ?
						ftts_pkg::ALPHA_ONE : 17'd0;
					mcand_q   <= frame.fixed_mode ? fixed_dt_q : frame.frame_seconds;
					mplier_q  <= frame.fixed_mode ? ts_pos : frame.scale_factor;
					hi_q      <= '0;
					cnt_q     <= '0;
				end
			end
			ST_TICK: begin
				ticks_q  <= tk_ticks;
				mcand_q  <= fixed_dt_q;
				mplier_q <= {18'd0, tk_ticks};
				hi_q     <= '0;
				cnt_q    <= '0;
			end
			ST_MUL: begin
				hi_q     <= mul_hi_nxt;
				lo_q     <= mul_lo_nxt;
				mplier_q <= {1'b0, mplier_q[23:1]};
				cnt_q    <= cnt_q + 5'd1;
				if (mul_last) begin
					res_sim_q <= (fixed_q && step_q) ? prod_low : prod_sh16;
				end
			end
			ST_ACC: ;
			ST_STEP: begin
				if (step_go) begin
					ticks_q <= ticks_q + 6'd1;
				end else begin
					rem_q <= ta_q[31:0];
					cnt_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q   <= div_ge ? div_diff[31:0] : div_r2[31:0];
				alpha_q <= {alpha_q[15:0], div_ge};
				cnt_q   <= cnt_q + 5'd1;
			end
			ST_FIN: begin
				if (res_load) begin
					result_q.update_logic    <= upd_q;
					result_q.camera_dt       <= upd_q ? secs_q : 32'd0;
					result_q.simulation_dt   <= res_sim_q;
					result_q.committed_ticks <= ticks_q;
					result_q.alpha           <= alpha_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/ftts_chk.sv -----
// Port-level checker for the fixed-timestep tick scheduler.
// Depends on ftts_pkg for the result struct; bound to the top level below.
module ftts_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              frame_valid,
	input logic              frame_stall,
	input logic              result_valid,
	input logic              result_stall,
	input ftts_pkg::result_t result
);

	// A result that is held back stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	// The block works on one item at a time, so a taken frame closes the input.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_stall |=> frame_stall)
		else $error("frame channel open right after an item was taken");

	// A frame with logic disabled reports nothing else either.
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.update_logic |->
		(result.camera_dt == 32'd0) && (result.simulation_dt == 40'sd0) &&
		(result.committed_ticks == 6'd0) && (result.alpha == 17'd0))
		else $error("disabled frame carries nonzero result fields");

	// Alpha never exceeds one.
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !result.alpha[16] || (result.alpha[15:0] == 16'd0))
		else $error("alpha above one");

endmodule

bind fixed_timestep_tick_scheduler_unit ftts_chk u_ftts_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.frame_valid  (frame_valid),
	.frame_stall  (frame_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
